// ----- design/lflt_pkg.sv -----
package lflt_pkg;

   localparam int KEY_W   = 32;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 8;
   localparam int REQ_W   = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   localparam logic [REQ_W-1:0] REQ_FAIL    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SUCCESS = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FAILURES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_MS   = 1'd1;

   localparam logic [COUNT_W-1:0] COUNT_CAP        = 8'hFF;
   localparam logic [COUNT_W-1:0] MAX_FAILURES_RST = 8'd5;
   localparam logic [TIME_W-1:0]  LOCKOUT_MS_RST   = 32'd300000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_FINISH
   } lflt_state_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic upd;
      logic fin;
   } lflt_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_busy;
   } lflt_sts_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [TIME_W-1:0]  last_seen;
      logic [COUNT_W-1:0] fail_count;
      logic [TIME_W-1:0]  lock_until;
   } lflt_entry_type;

endpackage

// ----- design/lflt_ctrl.sv -----
module lflt_ctrl
   import lflt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  lflt_sts_type sts,
   output lflt_cmd_type cmd
);

   lflt_state_type state_ff;
   lflt_state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (!sts.out_busy) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN:   cmd.scan_rd = 1'b1;
         ST_DRAIN:  cmd = '0;
         ST_UPDATE: cmd.upd = 1'b1;
         ST_FINISH: cmd.fin = !sts.out_busy;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/lflt_dp.sv -----
module lflt_dp
   import lflt_pkg::*;
#(
   parameter int NUM_SLOTS = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [KEY_W-1:0]      client_key,
   input  logic [TIME_W-1:0]     now_ms,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic                  out_is_locked,
   output logic [TIME_W-1:0]     out_remaining_ms,
   output logic                  out_tracked,
   input  lflt_cmd_type          cmd,
   output lflt_sts_type          sts
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   lflt_entry_type slot_mem [NUM_SLOTS];
   lflt_entry_type rd_data_ff;

   logic [COUNT_W-1:0] max_fail_ff;
   logic [TIME_W-1:0]  lockout_ff;

   logic [REQ_W-1:0]  req_type_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [TIME_W-1:0] now_ff;

   logic [NUM_SLOTS-1:0] valid_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [IDX_W-1:0]     rd_idx_in;
   logic                 ev_vld_ff;
   logic [IDX_W-1:0]     ev_idx_ff;

   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [COUNT_W-1:0] hit_fc_ff, hit_fc_in;
   logic [TIME_W-1:0]  hit_lu_ff, hit_lu_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               of_ff, of_in;
   logic [IDX_W-1:0]   of_idx_ff, of_idx_in;
   logic [TIME_W-1:0]  of_ls_ff, of_ls_in;
   logic               oa_ff, oa_in;
   logic [IDX_W-1:0]   oa_idx_ff, oa_idx_in;
   logic [TIME_W-1:0]  oa_ls_ff, oa_ls_in;

   logic ev_v;
   logic ev_la;

   logic               wr_en_ff, wr_en_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [COUNT_W-1:0] new_fc_ff, new_fc_in;
   logic [TIME_W-1:0]  new_lu_ff, new_lu_in;
   logic               trk_ff, trk_in;

   logic [IDX_W-1:0]   sel_idx;
   logic [COUNT_W-1:0] base_fc;
   logic [TIME_W-1:0]  base_lu;
   logic               base_la;
   logic [COUNT_W-1:0] fc_clr;
   logic [COUNT_W-1:0] fc_inc;
   logic [TIME_W-1:0]  lock_sum;

   logic               rsp_vld_ff, rsp_vld_in;
   logic               locked_in;
   logic [TIME_W-1:0]  remain_in;
   logic               locked_ff;
   logic [TIME_W-1:0]  remain_ff;
   logic               tracked_ff;

   assign sts.scan_last = (rd_idx_ff == IDX_W'(NUM_SLOTS - 1));
   assign sts.out_busy  = rsp_vld_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_fail_ff <= MAX_FAILURES_RST;
         lockout_ff  <= LOCKOUT_MS_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MAX_FAILURES: max_fail_ff <= csr_wdata[COUNT_W-1:0];
            CSR_LOCKOUT_MS:   lockout_ff  <= csr_wdata[TIME_W-1:0];
            default:          lockout_ff  <= lockout_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff <= req_type;
         key_ff      <= client_key;
         now_ff      <= now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin && wr_en_ff) begin
         slot_mem[wr_idx_ff] <= '{key: key_ff, last_seen: now_ff,
                                  fail_count: new_fc_ff, lock_until: new_lu_ff};
      end
      rd_data_ff <= slot_mem[rd_idx_ff];
   end

   assign rd_idx_in = cmd.load ? '0 : (cmd.scan_rd ? rd_idx_ff + 1'b1 : rd_idx_ff);

   assign ev_v  = valid_ff[ev_idx_ff];
   assign ev_la = (rd_data_ff.lock_until != '0) && (now_ff < rd_data_ff.lock_until);

   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_fc_in   = hit_fc_ff;
      hit_lu_in   = hit_lu_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      of_in       = of_ff;
      of_idx_in   = of_idx_ff;
      of_ls_in    = of_ls_ff;
      oa_in       = oa_ff;
      oa_idx_in   = oa_idx_ff;
      oa_ls_in    = oa_ls_ff;
      if (cmd.load) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
         of_in   = 1'b0;
         oa_in   = 1'b0;
      end else if (ev_vld_ff) begin
         if (ev_v && !hit_ff && rd_data_ff.key == key_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = ev_idx_ff;
            hit_fc_in  = rd_data_ff.fail_count;
            hit_lu_in  = rd_data_ff.lock_until;
         end
         if (!ev_v && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = ev_idx_ff;
         end
         if (ev_v && !ev_la && (!of_ff || rd_data_ff.last_seen < of_ls_ff)) begin
            of_in     = 1'b1;
            of_idx_in = ev_idx_ff;
            of_ls_in  = rd_data_ff.last_seen;
         end
         if (ev_v && (!oa_ff || rd_data_ff.last_seen < oa_ls_ff)) begin
            oa_in     = 1'b1;
            oa_idx_in = ev_idx_ff;
            oa_ls_in  = rd_data_ff.last_seen;
         end
      end
   end

   always_comb begin
      priority if (hit_ff) sel_idx = hit_idx_ff;
      else if (free_ff)    sel_idx = free_idx_ff;
      else if (of_ff)      sel_idx = of_idx_ff;
      else                 sel_idx = oa_idx_ff;
   end

   assign base_fc  = hit_ff ? hit_fc_ff : '0;
   assign base_lu  = hit_ff ? hit_lu_ff : '0;
   assign base_la  = (base_lu != '0) && (now_ff < base_lu);
   assign fc_clr   = (base_lu != '0) ? '0 : base_fc;
   assign fc_inc   = (fc_clr != COUNT_CAP) ? fc_clr + 1'b1 : fc_clr;
   assign lock_sum = now_ff + lockout_ff;

   always_comb begin
      wr_en_in  = 1'b0;
      wr_idx_in = hit_idx_ff;
      trk_in    = hit_ff;
      new_fc_in = base_fc;
      new_lu_in = base_lu;
      unique case (req_type_ff)
         REQ_FAIL: begin
            wr_en_in  = 1'b1;
            wr_idx_in = sel_idx;
            trk_in    = 1'b1;
            if (!base_la) begin
               new_fc_in = fc_inc;
               new_lu_in = (fc_inc >= max_fail_ff) ? lock_sum : '0;
            end
         end
         REQ_SUCCESS: begin
            wr_en_in = hit_ff;
            if (!base_la) begin
               new_fc_in = '0;
               new_lu_in = '0;
            end
         end
         default: begin
            wr_en_in = 1'b0;
         end
      endcase
   end

   assign locked_in  = (new_lu_ff != '0) && (now_ff < new_lu_ff);
   assign remain_in  = locked_in ? new_lu_ff - now_ff : '0;
   assign rsp_vld_in = cmd.fin ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         wr_idx_ff <= wr_idx_in;
         new_fc_ff <= new_fc_in;
         new_lu_ff <= new_lu_in;
      end
      if (cmd.fin) begin
         locked_ff  <= locked_in;
         remain_ff  <= remain_in;
         tracked_ff <= trk_ff;
      end
      hit_idx_ff  <= hit_idx_in;
      hit_fc_ff   <= hit_fc_in;
      hit_lu_ff   <= hit_lu_in;
      free_idx_ff <= free_idx_in;
      of_idx_ff   <= of_idx_in;
      of_ls_ff    <= of_ls_in;
      oa_idx_ff   <= oa_idx_in;
      oa_ls_ff    <= oa_ls_in;
      ev_idx_ff   <= rd_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rd_idx_ff  <= '0;
         ev_vld_ff  <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         of_ff      <= 1'b0;
         oa_ff      <= 1'b0;
         wr_en_ff   <= 1'b0;
         trk_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (cmd.fin && wr_en_ff) begin
            valid_ff[wr_idx_ff] <= 1'b1;
         end
         rd_idx_ff  <= rd_idx_in;
         ev_vld_ff  <= cmd.scan_rd;
         hit_ff     <= hit_in;
         free_ff    <= free_in;
         of_ff      <= of_in;
         oa_ff      <= oa_in;
         if (cmd.upd) begin
            wr_en_ff <= wr_en_in;
            trk_ff   <= trk_in;
         end
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_tvalid       = rsp_vld_ff;
   assign out_is_locked    = locked_ff;
   assign out_remaining_ms = remain_ff;
   assign out_tracked      = tracked_ff;

   // A result is only produced into an empty or draining output register.
   assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> !(rsp_vld_ff && !rsp_tready))
      else $error("result overwrote a pending transfer");

   assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> rsp_vld_ff)
      else $error("finished item did not raise rsp_tvalid");

   // A recorded failure always leaves the key in the table.
   assert property (@(posedge clock) disable iff (reset)
      cmd.fin && req_type_ff == REQ_FAIL |=> tracked_ff)
      else $error("failure left key untracked");

   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && locked_ff |-> tracked_ff && remain_ff != '0)
      else $error("locked result inconsistent");

endmodule

// ----- design/login_failure_lockout_table.sv -----
// Per-client login failure tracker with lockout over a table of NUM_SLOTS entries.
// Each request on req_ (failure, success or query) is scanned against every slot
// one entry per cycle through the single read port of the slot memory, and the
// next transfer is accepted only once the item has passed the scan, drain,
// update and finish states. The result waits in an output register, so the
// next request is accepted and scanned while it is still pending. An item stays
// in its last cycle until that register has been emptied or is being emptied,
// and only then does the block accept another request. Configuration writes on
// csr_ take effect at once and should be made while no request is in progress;
// no clearing pass is needed after reset.
module login_failure_lockout_table
   import lflt_pkg::*;
#(
   parameter int NUM_SLOTS = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // client_key[31:0], now_ms[63:32]
   input  logic [REQ_W-1:0]      req_tuser,   // req_type[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // is_locked[0], remaining_ms[32:1],
                                              // tracked[33], zero[39:34]
);

   lflt_cmd_type      cmd;
   lflt_sts_type      sts;
   logic              out_is_locked;
   logic [TIME_W-1:0] out_remaining_ms;
   logic              out_tracked;

   lflt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lflt_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_type         (req_tuser),
      .client_key       (req_tdata[KEY_W-1:0]),
      .now_ms           (req_tdata[KEY_W +: TIME_W]),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .out_is_locked    (out_is_locked),
      .out_remaining_ms (out_remaining_ms),
      .out_tracked      (out_tracked),
      .cmd              (cmd),
      .sts              (sts)
   );

   assign rsp_tdata = {{(RSP_DATA_W - TIME_W - 2){1'b0}}, out_tracked,
                       out_remaining_ms, out_is_locked};

endmodule
